>>> hw/rtl/slcfp_pkg.sv
// Shared types and constants for the sync/length/CRC16 frame parser.
package slcfp_pkg;

    localparam logic [7:0]  SYNC_FIRST_RST  = 8'hA5;
    localparam logic [7:0]  SYNC_SECOND_RST = 8'h5A;
    localparam logic [15:0] MAX_LENGTH_RST  = 16'd256;
    localparam logic [15:0] CRC_POLY        = 16'h1021;
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;

    localparam logic [1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [1:0] CFG_SYNC_SECOND = 2'd1;
    localparam logic [1:0] CFG_MAX_LENGTH  = 2'd2;

    typedef enum logic [2:0] {
        EV_PAYLOAD  = 3'd0,
        EV_GOOD     = 3'd1,
        EV_BAD_CRC  = 3'd2,
        EV_TOO_LONG = 3'd3,
        EV_OVERFLOW = 3'd4
    } t_event;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       overflow;
    } t_item;

    typedef struct packed {
        logic [7:0]  sync_first;
        logic [7:0]  sync_second;
        logic [15:0] max_length;
    } t_cfg;

    typedef struct packed {
        t_event      event_res;
        logic [7:0]  frame_type;
        logic [7:0]  data_byte;
        logic [15:0] byte_index;
        logic [15:0] frame_length;
    } t_result;

endpackage

>>> hw/rtl/slcfp_in_stage.sv
// Input register stage: captures one request per cycle and holds it under stall.
module slcfp_in_stage
    import slcfp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_item i_item,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_ready
);

    logic  r_valid;
    t_item r_item;

    assign o_stall = r_valid && !i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
        if (!o_stall && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

>>> hw/rtl/slcfp_parser.sv
// Frame parser state machine, CRC16 update and result register.
module slcfp_parser
    import slcfp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_valid,
    input  t_item   i_item,
    output logic    o_ready,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_result o_res
);

    typedef enum logic [2:0] {
        PH_SYNC0, PH_SYNC1, PH_TYPE, PH_LEN_LO,
        PH_LEN_HI, PH_PAYLOAD, PH_CHK_LO, PH_CHK_HI
    } t_phase;

    function automatic logic [15:0] f_crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] v;
        v = c ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            v = v[15] ? ({v[14:0], 1'b0} ^ CRC_POLY) : {v[14:0], 1'b0};
        end
        return v;
    endfunction

    t_phase      r_phase, n_phase;
    logic [7:0]  r_held_type, n_held_type;
    logic [15:0] r_held_length, n_held_length;
    logic [15:0] r_count, n_count;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_chk_lo, n_chk_lo;
    logic        r_out_valid, n_emit;
    t_result     r_res, n_res;

    logic        advance;
    logic [7:0]  b;
    logic [15:0] len_full;
    logic [15:0] count_inc;
    t_phase      ph;

    assign o_ready     = !r_out_valid || !i_out_stall;
    assign advance     = i_valid && o_ready;
    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;
    assign b           = i_item.rx_byte;
    assign len_full    = {b, r_held_length[7:0]};
    assign count_inc   = r_count + 16'd1;

    always_comb begin
        n_phase       = r_phase;
        n_held_type   = r_held_type;
        n_held_length = r_held_length;
        n_count       = r_count;
        n_crc         = r_crc;
        n_chk_lo      = r_chk_lo;
        n_emit        = 1'b0;
        n_res         = '{EV_PAYLOAD, r_held_type, 8'd0, 16'd0, r_held_length};
        ph            = r_phase;

        // overflow flushes the frame before the byte is parsed
        if (i_item.overflow) begin
            n_emit        = 1'b1;
            n_res         = '{EV_OVERFLOW, r_held_type, 8'd0, 16'd0, r_held_length};
            ph            = PH_SYNC0;
            n_held_length = 16'd0;
            n_count       = 16'd0;
        end

        case (ph)
            PH_SYNC0: begin
                n_phase = (b == i_cfg.sync_first) ? PH_SYNC1 : PH_SYNC0;
            end
            PH_SYNC1: begin
                n_phase = (b == i_cfg.sync_second) ? PH_TYPE : PH_SYNC0;
            end
            PH_TYPE: begin
                n_held_type = b;
                n_crc       = f_crc_byte(CRC_INIT, b);
                n_phase     = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_held_length = {8'd0, b};
                n_crc         = f_crc_byte(r_crc, b);
                n_phase       = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                n_crc   = f_crc_byte(r_crc, b);
                n_count = 16'd0;
                if (len_full > i_cfg.max_length) begin
                    n_emit        = 1'b1;
                    n_res         = '{EV_TOO_LONG, r_held_type, 8'd0, 16'd0, len_full};
                    n_held_length = 16'd0;
                    n_phase       = PH_SYNC0;
                end else begin
                    n_held_length = len_full;
                    n_phase       = (len_full == 16'd0) ? PH_CHK_LO : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                n_crc   = f_crc_byte(r_crc, b);
                n_emit  = 1'b1;
                n_res   = '{EV_PAYLOAD, r_held_type, b, r_count, r_held_length};
                n_count = count_inc;
                if (count_inc == r_held_length) begin
                    n_phase = PH_CHK_LO;
                end
            end
            PH_CHK_LO: begin
                n_chk_lo = b;
                n_phase  = PH_CHK_HI;
            end
            default: begin
                n_emit = 1'b1;
                if ({b, r_chk_lo} == r_crc) begin
                    n_res = '{EV_GOOD, r_held_type, 8'd0, 16'd0, r_held_length};
                end else begin
                    n_res = '{EV_BAD_CRC, r_held_type, 8'd0, 16'd0, r_held_length};
                end
                n_held_length = 16'd0;
                n_count       = 16'd0;
                n_phase       = PH_SYNC0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_SYNC0;
            r_held_type   <= 8'd0;
            r_held_length <= 16'd0;
            r_count       <= 16'd0;
            r_crc         <= CRC_INIT;
            r_chk_lo      <= 8'd0;
            r_out_valid   <= 1'b0;
        end else begin
            if (o_ready) begin
                r_out_valid <= advance && n_emit;
            end
            if (advance) begin
                r_phase       <= n_phase;
                r_held_type   <= n_held_type;
                r_held_length <= n_held_length;
                r_count       <= n_count;
                r_crc         <= n_crc;
                r_chk_lo      <= n_chk_lo;
            end
        end
        if (advance && n_emit) begin
            r_res <= n_res;
        end
    end

endmodule

>>> hw/rtl/sync_length_crc16_frame_parser_unit.sv
// Top level of the sync/length/CRC16 frame parser with its config registers.
//
// Input channel: i_rx_byte and i_overflow, one request per cycle, taken
// when i_in_valid is high and o_in_stall is low. The parser hunts for two
// sync bytes, reads a type byte and a little-endian 16-bit length, then
// the payload and a little-endian CRC-16/CCITT-FALSE over type, length
// and payload.
// Output channel: one result register; a request yields zero or one
// result (payload byte, frame verdict, length error or overflow reset),
// taken when o_out_valid is high and i_out_stall is low.
// Path: a request is captured in the input register, and its result is
// written to the result register when the parser accepts it.
// Throughput: one request per cycle while the output is not stalled; the
// CRC byte update and phase decode are combinational.
// Stall: a stalled result holds; one more request is held in the input
// register, after which o_in_stall rises.
// Config: write i_cfg_data to register i_cfg_index (0 sync_first,
// 1 sync_second, 2 max_length) while idle; o_cfg_ready is always high.
// Reset: synchronous, active low; parser hunts the first sync byte,
// config returns to 0xA5, 0x5A, 256.
module sync_length_crc16_frame_parser_unit
    import slcfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_overflow,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_event_res,
    output logic [7:0]  o_frame_type,
    output logic [7:0]  o_data_byte,
    output logic [15:0] o_byte_index,
    output logic [15:0] o_frame_length,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cfg    r_cfg;
    t_item   in_item;
    t_item   st_item;
    logic    st_valid;
    logic    st_ready;
    t_result res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{SYNC_FIRST_RST, SYNC_SECOND_RST, MAX_LENGTH_RST};
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SYNC_FIRST:  r_cfg.sync_first  <= i_cfg_data[7:0];
                CFG_SYNC_SECOND: r_cfg.sync_second <= i_cfg_data[7:0];
                CFG_MAX_LENGTH:  r_cfg.max_length  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign in_item = '{i_rx_byte, i_overflow};

    slcfp_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (in_item),
        .o_valid (st_valid),
        .o_item  (st_item),
        .i_ready (st_ready)
    );

    slcfp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (st_valid),
        .i_item      (st_item),
        .o_ready     (st_ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_res       (res)
    );

    assign o_event_res    = res.event_res;
    assign o_frame_type   = res.frame_type;
    assign o_data_byte    = res.data_byte;
    assign o_byte_index   = res.byte_index;
    assign o_frame_length = res.frame_length;

endmodule

>>> hw/rtl/slcfp_checker.sv
// Port-level assertions for the frame parser, bound to the top level.
module slcfp_checker
    import slcfp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [2:0]  o_event_res,
    input logic [7:0]  o_data_byte,
    input logic [15:0] o_byte_index,
    input logic [15:0] o_frame_length
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped under stall");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_verdict_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_event_res != EV_PAYLOAD |->
            o_data_byte == 8'd0 && o_byte_index == 16'd0)
        else $error("non-payload result carries data");

    a_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_event_res == EV_PAYLOAD |-> o_byte_index < o_frame_length)
        else $error("payload index beyond length");

endmodule

bind sync_length_crc16_frame_parser_unit slcfp_checker u_chk (.*);

>>> dv/testbench.sv
// Self-checking testbench for the sync/length/CRC16 frame parser unit.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import slcfp_pkg::*;

    typedef enum logic [2:0] {
        HUNT_FIRST, HUNT_SECOND, GET_TYPE, GET_LEN_LO,
        GET_LEN_HI, GET_PAYLOAD, GET_CHECK_LO, GET_CHECK_HI
    } t_parse_phase;

    typedef enum int {FLAW_NONE, FLAW_BAD_CRC, FLAW_BAD_SYNC} t_flaw;

    class deframer_shadow;
        logic [7:0]   sync_first;
        logic [7:0]   sync_second;
        logic [15:0]  max_length;
        t_parse_phase phase;
        logic [7:0]   held_type;
        logic [15:0]  held_length;
        logic [15:0]  payload_count;
        logic [15:0]  running_crc;
        logic [7:0]   crc_low;
        t_result      expected[$];
        int           requests;
        int           results;
        int           errors;
        int           seen[5];

        function new();
            sync_first    = SYNC_FIRST_RST;
            sync_second   = SYNC_SECOND_RST;
            max_length    = MAX_LENGTH_RST;
            phase         = HUNT_FIRST;
            held_type     = '0;
            held_length   = '0;
            payload_count = '0;
            running_crc   = CRC_INIT;
            crc_low       = '0;
        endfunction

        static function logic [15:0] crc_update(logic [15:0] crc, logic [7:0] b);
            logic [15:0] c;
            int k;
            c = crc ^ {b, 8'h00};
            for (k = 0; k < 8; k++) begin
                c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
            end
            return c;
        endfunction

        function void write_register(logic [1:0] idx, logic [15:0] data);
            case (idx)
                CFG_SYNC_FIRST:  sync_first  = data[7:0];
                CFG_SYNC_SECOND: sync_second = data[7:0];
                CFG_MAX_LENGTH:  max_length  = data;
                default: ;
            endcase
        endfunction

        function void push(t_event ev, logic [7:0] data, logic [15:0] idx, logic [15:0] len);
            t_result r;
            r.event_res    = ev;
            r.frame_type   = held_type;
            r.data_byte    = data;
            r.byte_index   = idx;
            r.frame_length = len;
            expected.push_back(r);
        endfunction

        function void restart_hunt();
            phase         = HUNT_FIRST;
            payload_count = '0;
            held_length   = '0;
        endfunction

        function void take_byte(logic [7:0] b, logic ovf);
            requests++;
            if (ovf) begin
                push(EV_OVERFLOW, 8'h00, 16'h0000, held_length);
                restart_hunt();
            end
            case (phase)
                HUNT_FIRST: begin
                    phase = (b == sync_first) ? HUNT_SECOND : HUNT_FIRST;
                end
                HUNT_SECOND: begin
                    phase = (b == sync_second) ? GET_TYPE : HUNT_FIRST;
                end
                GET_TYPE: begin
                    held_type   = b;
                    running_crc = crc_update(CRC_INIT, b);
                    phase       = GET_LEN_LO;
                end
                GET_LEN_LO: begin
                    held_length = {8'h00, b};
                    running_crc = crc_update(running_crc, b);
                    phase       = GET_LEN_HI;
                end
                GET_LEN_HI: begin
                    held_length   = {b, held_length[7:0]};
                    running_crc   = crc_update(running_crc, b);
                    payload_count = '0;
                    if (held_length > max_length) begin
                        push(EV_TOO_LONG, 8'h00, 16'h0000, held_length);
                        restart_hunt();
                    end else begin
                        phase = (held_length == 0) ? GET_CHECK_LO : GET_PAYLOAD;
                    end
                end
                GET_PAYLOAD: begin
                    running_crc = crc_update(running_crc, b);
                    push(EV_PAYLOAD, b, payload_count, held_length);
                    payload_count++;
                    if (payload_count == held_length) begin
                        phase = GET_CHECK_LO;
                    end
                end
                GET_CHECK_LO: begin
                    crc_low = b;
                    phase   = GET_CHECK_HI;
                end
                default: begin
                    push(({b, crc_low} == running_crc) ? EV_GOOD : EV_BAD_CRC,
                         8'h00, 16'h0000, held_length);
                    restart_hunt();
                end
            endcase
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void match_event(t_result got);
            t_result want;
            results++;
            if (expected.size() == 0) begin
                $error("event_res: expected none, got 0x%0h", got.event_res);
                errors++;
                return;
            end
            want = expected.pop_front();
            seen[int'(want.event_res)]++;
            compare_field("event_res", 16'(want.event_res), 16'(got.event_res));
            compare_field("frame_type", 16'(want.frame_type), 16'(got.frame_type));
            compare_field("data_byte", 16'(want.data_byte), 16'(got.data_byte));
            compare_field("byte_index", want.byte_index, got.byte_index);
            compare_field("frame_length", want.frame_length, got.frame_length);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_rx_byte;
    logic        i_overflow;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [2:0]  o_event_res;
    logic [7:0]  o_frame_type;
    logic [7:0]  o_data_byte;
    logic [15:0] o_byte_index;
    logic [15:0] o_frame_length;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    deframer_shadow shadow;
    int             sent;
    int             in_mode;
    int             out_mode;
    bit             inject_overflow;
    int             settings_used;

    sync_length_crc16_frame_parser_unit dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int draw_wait(int mode);
        case (mode)
            0: return 0;
            1: return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 17) : 0;
            default: return $urandom_range(0, 17);
        endcase
    endfunction

    task automatic send_request(input logic [7:0] b, input logic ovf);
        int gap;
        gap = draw_wait(in_mode);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_rx_byte  = b;
        i_overflow = ovf;
        i_in_valid = 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        shadow.take_byte(b, ovf);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_request(b, inject_overflow && ($urandom_range(0, 59) == 0));
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [15:0] data);
        i_cfg_index = idx;
        i_cfg_data  = data;
        i_cfg_valid = 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        shadow.write_register(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_registers(input logic [7:0] s1, input logic [7:0] s2,
                                 input logic [15:0] max_len);
        write_register(CFG_SYNC_FIRST, {8'h00, s1});
        write_register(CFG_SYNC_SECOND, {8'h00, s2});
        write_register(CFG_MAX_LENGTH, max_len);
    endtask

    task automatic settle();
        i_in_valid = 1'b0;
        while (shadow.expected.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic send_frame(input logic [7:0] ftype, input logic [15:0] len,
                              input t_flaw flaw);
        logic [15:0] crc;
        logic [7:0]  b;
        int          k;
        send_byte(shadow.sync_first);
        if (flaw == FLAW_BAD_SYNC) begin
            b = 8'($urandom_range(0, 255));
            if (b == shadow.sync_second) b = ~b;
            send_byte(b);
            return;
        end
        send_byte(shadow.sync_second);
        crc = deframer_shadow::crc_update(CRC_INIT, ftype);
        crc = deframer_shadow::crc_update(crc, len[7:0]);
        crc = deframer_shadow::crc_update(crc, len[15:8]);
        send_byte(ftype);
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        if (len > shadow.max_length) return;
        for (k = 0; k < len; k++) begin
            b   = 8'($urandom_range(0, 255));
            crc = deframer_shadow::crc_update(crc, b);
            send_byte(b);
        end
        if (flaw == FLAW_BAD_CRC) crc ^= 16'($urandom_range(1, 65535));
        send_byte(crc[7:0]);
        send_byte(crc[15:8]);
    endtask

    task automatic random_frame();
        int          roll;
        int          lim;
        int          n;
        logic [7:0]  b;
        logic [15:0] len;
        t_flaw       flaw;
        if ($urandom_range(0, 9) == 0) begin
            in_mode  = $urandom_range(0, 2);
            out_mode = $urandom_range(0, 2);
        end
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 6);
            repeat (n) begin
                b = 8'($urandom_range(0, 255));
                if (b == shadow.sync_first) b = ~b;
                send_byte(b);
            end
        end
        roll = $urandom_range(0, 99);
        flaw = (roll < 8) ? FLAW_BAD_SYNC : (roll < 28) ? FLAW_BAD_CRC : FLAW_NONE;
        roll = $urandom_range(0, 99);
        lim  = (roll < 6) ? 40 : 10;
        if (shadow.max_length < lim) lim = int'(shadow.max_length);
        if (roll >= 88 && shadow.max_length != 16'hFFFF) begin
            len = 16'($urandom_range(int'(shadow.max_length) + 1, 65535));
        end else begin
            len = 16'($urandom_range(0, lim));
        end
        send_frame(8'($urandom_range(0, 255)), len, flaw);
    endtask

    initial begin
        i_out_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            t_result got;
            int      hold;
            hold = draw_wait(out_mode);
            if (hold > 0) begin
                i_out_stall = 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_out_stall = 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            got.event_res    = t_event'(o_event_res);
            got.frame_type   = o_frame_type;
            got.data_byte    = o_data_byte;
            got.byte_index   = o_byte_index;
            got.frame_length = o_frame_length;
            shadow.match_event(got);
            @(negedge i_clk);
        end
    end

    initial begin
        int target;
        int step;
        shadow          = new();
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_rx_byte       = '0;
        i_overflow      = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        sent            = 0;
        in_mode         = 0;
        out_mode        = 0;
        inject_overflow = 1'b0;
        settings_used   = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: overflow while hunting, zero length, bad crc,
        // repeated first sync, overlong length, overflow mid-header
        send_request(8'hFF, 1'b1);
        send_frame(8'hFF, 16'h0000, FLAW_NONE);
        send_frame(8'h00, 16'h0001, FLAW_BAD_CRC);
        send_request(8'hA5, 1'b0);
        send_request(8'hA5, 1'b0);
        send_frame(8'h12, 16'h0101, FLAW_NONE);
        send_request(8'hA5, 1'b0);
        send_request(8'h5A, 1'b0);
        send_request(8'h07, 1'b0);
        send_request(8'h02, 1'b0);
        send_request(8'h00, 1'b1);
        settle();

        for (step = 0; step < 6; step++) begin
            case (step)
                0: ;
                1: set_registers(8'h00, 8'hFF, 16'h0000);
                2: begin
                    set_registers(8'hFF, 8'h00, 16'hFFFF);
                    // longest legal length, cut short by an overflow
                    send_request(8'hFF, 1'b0);
                    send_request(8'h00, 1'b0);
                    send_request(8'h3C, 1'b0);
                    send_request(8'hFF, 1'b0);
                    send_request(8'hFF, 1'b0);
                    repeat (3) send_request(8'($urandom_range(0, 255)), 1'b0);
                    send_request(8'h00, 1'b1);
                end
                5: set_registers(SYNC_FIRST_RST, SYNC_SECOND_RST, MAX_LENGTH_RST);
                default: set_registers(8'($urandom_range(0, 255)),
                                       8'($urandom_range(0, 255)),
                                       ($urandom_range(0, 3) == 0) ?
                                       16'($urandom_range(0, 65535)) :
                                       16'($urandom_range(0, 16)));
            endcase
            settings_used++;
            inject_overflow = 1'b1;
            target = sent + 100;
            while (sent < target) random_frame();
            inject_overflow = 1'b0;
            settle();
        end

        $display("Covered %0d bytes under %0d register settings, %0d events checked",
                 shadow.requests, settings_used, shadow.results);
        $display("payload %0d, good %0d, crc mismatch %0d, too long %0d, overflow %0d",
                 shadow.seen[EV_PAYLOAD], shadow.seen[EV_GOOD], shadow.seen[EV_BAD_CRC],
                 shadow.seen[EV_TOO_LONG], shadow.seen[EV_OVERFLOW]);
        if (shadow.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d events still outstanding", shadow.expected.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
